// ----- rtl/core/clc_pkg.sv -----
`timescale 1ns / 1ps

package clc_pkg;

	// Width of the convolution sum; wider sums wrap at this width.
	localparam int CONV_BITS = 42;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RUN,
		S_DRAIN,
		S_DONE
	} state_t;

	typedef struct packed {
		logic clear;
		logic valid;
	} mac_ctl_t;

endpackage

// ----- rtl/core/clc_mac.sv -----
`timescale 1ns / 1ps

module clc_mac
	import clc_pkg::*;
#(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mac_ctl_t                      ctl,
	input  logic signed [SAMPLE_BITS-1:0] a,
	input  logic signed [SAMPLE_BITS-1:0] b,
	output logic signed [CONV_BITS-1:0]   acc,
	output logic                          busy
);

	localparam int PROD_W = 2 * SAMPLE_BITS;

	logic signed [PROD_W-1:0]    prod_s2;
	logic                        prod_vld_s2;
	logic signed [CONV_BITS-1:0] acc_q;

	always_ff @(posedge clk) begin
		prod_s2 <= PROD_W'(a) * PROD_W'(b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_vld_s2 <= 1'b0;
		end else begin
			prod_vld_s2 <= ctl.valid;
		end
	end

	// The product is sign extended (or cut) to the sum width; the sum wraps.
	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			acc_q <= '0;
		end else if (prod_vld_s2) begin
			acc_q <= acc_q + CONV_BITS'(prod_s2);
		end
	end

	assign acc  = acc_q;
	assign busy = prod_vld_s2;

endmodule

// ----- rtl/core/causal_linear_convolution.sv -----
`timescale 1ns / 1ps
// A transaction's result passes the registered memory read, the product register and the accumulator
// into the result register; a new transaction is accepted only once that result has been loaded.
// Throughput is set by the single multiply-accumulate unit, one product per cycle.
// Items past MAX_LEN skip the accumulation and give a zero value with too_long set.
// Reset clears the sample index and all control state; the sample memories are not cleared.
module causal_linear_convolution
	import clc_pkg::*;
#(
	parameter int MAX_LEN     = 1024,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_ready,
	input  logic signed [SAMPLE_BITS-1:0] signal_sample,
	input  logic signed [SAMPLE_BITS-1:0] kernel_tap,
	input  logic                          is_last,
	output logic                          result_valid,
	input  logic                          result_ready,
	output logic signed [CONV_BITS-1:0]   conv_value,
	output logic                          conv_last,
	output logic                          too_long
);

	localparam int AW    = $clog2(MAX_LEN);
	localparam int IDX_W = $clog2(MAX_LEN + 1);

	state_t state_q, state_d;

	logic [IDX_W-1:0] idx_q;
	logic [AW-1:0]    n_q;
	logic [AW-1:0]    k_q;
	logic [AW-1:0]    ker_addr;
	logic             last_q;
	logic             ovf_q;
	logic             ovf_in;
	logic             accept;
	logic             load_res;

	logic signed [SAMPLE_BITS-1:0] sig_mem [MAX_LEN];
	logic signed [SAMPLE_BITS-1:0] ker_mem [MAX_LEN];
	logic signed [SAMPLE_BITS-1:0] sig_rd_s1;
	logic signed [SAMPLE_BITS-1:0] ker_rd_s1;
	logic                          rd_vld_s1;

	mac_ctl_t                    mac_ctl;
	logic signed [CONV_BITS-1:0] mac_acc;
	logic                        mac_busy;

	logic                        result_valid_q;
	logic signed [CONV_BITS-1:0] conv_value_q;
	logic                        conv_last_q;
	logic                        too_long_q;

	assign accept   = item_valid && item_ready;
	assign ovf_in   = (idx_q >= IDX_W'(MAX_LEN));
	assign ker_addr = n_q - k_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		item_ready  = 1'b0;
		load_res    = 1'b0;
		mac_ctl     = '0;
		mac_ctl.valid = rd_vld_s1;
		case (state_q)
			S_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					mac_ctl.clear = 1'b1;
					state_d = ovf_in ? S_DONE : S_RUN;
				end
			end
			S_RUN: begin
				if (k_q == n_q) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (!rd_vld_s1 && !mac_busy) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!result_valid_q || result_ready) begin
					load_res = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// The index saturates at MAX_LEN and returns to zero after a last sample.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			n_q    <= '0;
			k_q    <= '0;
			last_q <= 1'b0;
			ovf_q  <= 1'b0;
		end else if (accept) begin
			n_q    <= idx_q[AW-1:0];
			k_q    <= '0;
			last_q <= is_last;
			ovf_q  <= ovf_in;
			if (is_last) begin
				idx_q <= '0;
			end else if (ovf_in) begin
				idx_q <= IDX_W'(MAX_LEN);
			end else begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end else if (state_q == S_RUN) begin
			k_q <= k_q + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !ovf_in) begin
			sig_mem[idx_q[AW-1:0]] <= signal_sample;
			ker_mem[idx_q[AW-1:0]] <= kernel_tap;
		end
	end

	// Pair x[k] with h[n - k]; the read data is registered before the multiplier.
	always_ff @(posedge clk) begin
		sig_rd_s1 <= sig_mem[k_q];
		ker_rd_s1 <= ker_mem[ker_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == S_RUN);
		end
	end

	clc_mac #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_mac (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (mac_ctl),
		.a     (sig_rd_s1),
		.b     (ker_rd_s1),
		.acc   (mac_acc),
		.busy  (mac_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (load_res) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			conv_value_q <= ovf_q ? '0 : mac_acc;
			conv_last_q  <= last_q;
			too_long_q   <= ovf_q;
		end
	end

	assign result_valid = result_valid_q;
	assign conv_value   = conv_value_q;
	assign conv_last    = conv_last_q;
	assign too_long     = too_long_q;

	a_overflow_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && too_long_q |-> conv_value_q == '0)
		else $error("overflow transaction carries a nonzero value");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !item_ready)
		else $error("input accepted again before the result was formed");

	a_tap_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RUN |-> k_q <= n_q)
		else $error("tap counter ran past the sample index");

	a_index_bound: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= IDX_W'(MAX_LEN))
		else $error("sample index beyond saturation");

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
	import clc_pkg::*;

	localparam int MAX_LEN        = 1024;
	localparam int SAMPLE_BITS    = 16;
	localparam int RANDOM_ITEMS   = 560;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int LONG_HOLD      = 400;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	typedef struct {
		logic signed [CONV_BITS-1:0] value;
		logic                        last;
		logic                        overflow;
	} conv_result_t;

	// Keeps its own copy of the sequence history and predicts every output sample.
	class conv_sum_tracker;
		sample_t      signal_hist[MAX_LEN];
		sample_t      tap_hist[MAX_LEN];
		int unsigned  seq_pos;
		conv_result_t pending_sums[$];
		int           mismatches;
		int           results_seen;

		function new();
			seq_pos      = 0;
			mismatches   = 0;
			results_seen = 0;
		endfunction

		function void note_sample(sample_t x, sample_t h, logic last);
			conv_result_t r;
			longint       acc;
			acc        = 0;
			r.overflow = 1'b0;
			if (seq_pos >= MAX_LEN) begin
				seq_pos    = MAX_LEN;
				r.overflow = 1'b1;
			end else begin
				signal_hist[seq_pos] = x;
				tap_hist[seq_pos]    = h;
				for (int k = 0; k <= seq_pos; k++)
					acc += longint'(signal_hist[k]) * longint'(tap_hist[seq_pos - k]);
				seq_pos++;
			end
			if (last)
				seq_pos = 0;
			r.value = acc[CONV_BITS-1:0];
			r.last  = last;
			pending_sums.push_back(r);
		endfunction

		function void check_result(logic signed [CONV_BITS-1:0] value, logic last,
				logic overflow);
			conv_result_t r;
			results_seen++;
			if (pending_sums.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d arrived with nothing pending: value %0d last %b too_long %b",
						results_seen, value, last, overflow);
				return;
			end
			r = pending_sums.pop_front();
			if (value !== r.value || last !== r.last || overflow !== r.overflow) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d: expected value %0d last %b too_long %b, got value %0d last %b too_long %b",
						results_seen, r.value, r.last, r.overflow, value, last, overflow);
			end
		endfunction
	endclass

	logic                        clk;
	logic                        arst_n;
	logic                        item_valid;
	logic                        item_ready;
	sample_t                     signal_sample;
	sample_t                     kernel_tap;
	logic                        is_last;
	logic                        result_valid;
	logic                        result_ready;
	logic signed [CONV_BITS-1:0] conv_value;
	logic                        conv_last;
	logic                        too_long;

	conv_sum_tracker sums;
	int              burst_left = 0;
	int              idle_cycles = 0;

	causal_linear_convolution #(
		.MAX_LEN(MAX_LEN),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.signal_sample(signal_sample),
		.kernel_tap(kernel_tap),
		.is_last(is_last),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.conv_value(conv_value),
		.conv_last(conv_last),
		.too_long(too_long)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic sample_t pick_sample();
		case ($urandom_range(0, 9))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return '0;
			3: return '1;
			default: return sample_t'($urandom);
		endcase
	endfunction

	// Offers one transaction and returns at the edge where it is taken.
	task automatic send_sample(input sample_t x, input sample_t h, input logic last);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
			if (gap > 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		burst_left--;
		item_valid    <= 1'b1;
		signal_sample <= x;
		kernel_tap    <= h;
		is_last       <= last;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		sums.note_sample(x, h, last);
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			sums.check_result(conv_value, conv_last, too_long);
	end

	always @(posedge clk) begin
		if (!arst_n || (item_valid && item_ready) || (result_valid && result_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Result side: a rotating ready pattern, plus one long hold-off so the block backs up.
	initial begin : result_sink
		logic [15:0] ready_pattern;
		int          phase;
		bit          held_off;
		held_off = 1'b0;
		result_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			case ($urandom_range(0, 3))
				0: ready_pattern = 16'hffff;
				1: ready_pattern = 16'h5555;
				default: ready_pattern = 16'($urandom);
			endcase
			if (ready_pattern == '0)
				ready_pattern = 16'h0001;
			for (phase = 0; phase < 64; phase++) begin
				@(posedge clk);
				if (!held_off && sums.results_seen >= 150) begin
					held_off = 1'b1;
					result_ready <= 1'b0;
					repeat (LONG_HOLD) @(posedge clk);
				end else begin
					result_ready <= ready_pattern[phase % 16];
				end
			end
		end
	end

	initial begin
		int  sent;
		int  pick;
		int  seq_len;
		bit  close_seq;
		sums = new();
		arst_n        <= 1'b0;
		item_valid    <= 1'b0;
		signal_sample <= '0;
		kernel_tap    <= '0;
		is_last       <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Single-sample sequences at the corners of the Q1.15 range.
		send_sample(16'sh8000, 16'sh8000, 1'b1);
		send_sample(16'sh7fff, 16'sh7fff, 1'b1);
		send_sample(16'sh8000, 16'sh7fff, 1'b1);
		send_sample(16'sh0000, 16'sh0000, 1'b1);

		send_sample(16'sh7fff, 16'sh8000, 1'b0);
		send_sample(16'sh8000, 16'sh8000, 1'b0);
		send_sample(16'shffff, 16'sh0001, 1'b0);
		send_sample(16'sh0001, 16'shffff, 1'b0);
		send_sample(16'sh4000, 16'shc000, 1'b0);
		send_sample(16'sh8000, 16'sh7fff, 1'b0);
		send_sample(16'sh7fff, 16'sh7fff, 1'b0);
		send_sample(16'sh8000, 16'sh8000, 1'b1);

		send_sample(16'sh5555, 16'shaaaa, 1'b0);
		send_sample(16'shaaaa, 16'sh5555, 1'b0);
		send_sample(16'sh5555, 16'sh5555, 1'b0);
		send_sample(16'shaaaa, 16'shaaaa, 1'b0);
		send_sample(16'sh00ff, 16'shff00, 1'b0);
		send_sample(16'shff00, 16'sh00ff, 1'b1);

		// Mostly short sequences; some are left open and run into the next one.
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 80)
				seq_len = $urandom_range(1, 20);
			else if (pick < 96)
				seq_len = $urandom_range(21, 80);
			else
				seq_len = $urandom_range(150, 300);
			if (seq_len > RANDOM_ITEMS - sent)
				seq_len = RANDOM_ITEMS - sent;
			close_seq = ($urandom_range(0, 9) != 0);
			for (int i = 0; i < seq_len; i++)
				send_sample(pick_sample(), pick_sample(), close_seq && (i == seq_len - 1));
			sent += seq_len;
		end
		send_sample(pick_sample(), pick_sample(), 1'b1);

		item_valid <= 1'b0;
		while (sums.pending_sums.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (sums.mismatches == 0 && sums.pending_sums.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
